### rtl/core/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache.
`timescale 1ns / 1ps
`default_nettype none
package lkvc_pkg;

    localparam int DEFAULT_ENTRIES       = 16;
    localparam int DEFAULT_PAYLOAD_WIDTH = 64;
    localparam int KEY_W                 = 32;
    localparam int CAP_W                 = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef struct packed {
        logic look;
        logic apply;
        logic is_put;
        logic is_hit;
        logic do_evict;
    } cell_ctl_t;

endpackage
`default_nettype wire

### rtl/core/lkvc_cell.sv
// One cache cell: key, payload, valid bit and recency rank, with neighbor chain.
`timescale 1ns / 1ps
`default_nettype none
module lkvc_cell #(
    parameter int ENTRIES       = lkvc_pkg::DEFAULT_ENTRIES,
    parameter int PAYLOAD_WIDTH = lkvc_pkg::DEFAULT_PAYLOAD_WIDTH,
    parameter int CELL_IDX      = 0
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  lkvc_pkg::cell_ctl_t              ctl,
    input  wire  [lkvc_pkg::KEY_W-1:0]       key,
    input  wire  [PAYLOAD_WIDTH-1:0]         pay,
    input  wire  [$clog2(ENTRIES+1)-1:0]     used_count,
    input  wire  [$clog2(ENTRIES)-1:0]       hit_rank,
    input  wire                              found_in,
    input  wire  [PAYLOAD_WIDTH-1:0]         pay_in,
    input  wire  [$clog2(ENTRIES)-1:0]       rank_in,
    output logic                             found_out,
    output logic [PAYLOAD_WIDTH-1:0]         pay_out,
    output logic [$clog2(ENTRIES)-1:0]       rank_out
);
    import lkvc_pkg::*;

    localparam int RANK_W = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES+1);
    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(CELL_IDX);

    logic [KEY_W-1:0]         key_reg;
    logic [PAYLOAD_WIDTH-1:0] payload_reg;
    logic                     valid_reg;
    logic                     valid_next;
    logic [RANK_W-1:0]        rank_reg;
    logic [RANK_W-1:0]        rank_next;
    logic                     match_reg;
    logic                     target;
    logic                     write_pay;
    logic [RANK_W-1:0]        oldest_rank;

    assign found_out = found_in | match_reg;
    assign pay_out   = pay_in | (match_reg ? payload_reg : '0);
    assign rank_out  = rank_in | (match_reg ? rank_reg : '0);

    assign oldest_rank = RANK_W'(used_count - CNT_W'(1));
    assign target = ctl.do_evict ? (valid_reg && rank_reg == oldest_rank)
                                 : (used_count == MY_IDX);

    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        write_pay  = 1'b0;
        if (ctl.apply)
        begin
            if (ctl.is_hit)
            begin
                if (match_reg)
                begin
                    rank_next = '0;
                    write_pay = ctl.is_put;
                end
                else if (valid_reg && rank_reg < hit_rank)
                begin
                    rank_next = rank_reg + RANK_W'(1);
                end
            end
            else if (ctl.is_put)
            begin
                if (target)
                begin
                    valid_next = 1'b1;
                    rank_next  = '0;
                    write_pay  = 1'b1;
                end
                else if (valid_reg)
                begin
                    rank_next = rank_reg + RANK_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
            if (ctl.look)
            begin
                match_reg <= valid_reg && (key_reg == key);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_pay)
        begin
            payload_reg <= pay;
        end
        if (ctl.apply && !ctl.is_hit && ctl.is_put && target)
        begin
            key_reg <= key;
        end
    end

endmodule
`default_nettype wire

### rtl/core/lru_key_value_cache.sv
// Top level of the LRU key-value cache: stream ports, control and the row of cells.
//
// Usage: items enter on the s_axis channel; s_axis_tuser carries the command
// (get or put), s_axis_tdata the key and the payload. Each item yields exactly
// one result on the m_axis channel: found flag, payload read by a get hit, and
// an evicted flag for a put that pushed out the least recent entry.
// The capacity register is written on the cfg channel (always ready); write it
// only while no item is in flight.
// Sequence: the key is compared in every cell (look step), then the hit is
// gathered along the cell chain, ranks are updated and the result is
// registered (update step). A new item is taken only after the last one has
// left the three-step sequencer around the cell row.
// The output register holds its result until the receiver takes it; a stalled
// receiver holds the sequencer in its update step and s_axis_tready low.
// Reset empties the cache and sets the capacity to 16 entries.
`timescale 1ns / 1ps
`default_nettype none
module lru_key_value_cache #(
    parameter int ENTRIES       = lkvc_pkg::DEFAULT_ENTRIES,
    parameter int PAYLOAD_WIDTH = lkvc_pkg::DEFAULT_PAYLOAD_WIDTH
) (
    input  wire                                                   clk,
    input  wire                                                   rst_n,
    input  wire                                                   s_axis_tvalid,
    output logic                                                  s_axis_tready,
    // lookup_key [31:0], payload_in [32 +: PAYLOAD_WIDTH], zero pad
    input  wire  [((lkvc_pkg::KEY_W+PAYLOAD_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    // cmd
    input  wire                                                   s_axis_tuser,
    output logic                                                  m_axis_tvalid,
    input  wire                                                   m_axis_tready,
    // found [0], payload_out [1 +: PAYLOAD_WIDTH], evicted, zero pad
    output logic [((PAYLOAD_WIDTH+2+7)/8)*8-1:0]                  m_axis_tdata,
    input  wire                                                   cfg_valid,
    output logic                                                  cfg_ready,
    input  wire  [lkvc_pkg::CAP_W-1:0]                            cfg_data
);
    import lkvc_pkg::*;

    localparam int RANK_W = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES+1);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int OUT_W  = ((PAYLOAD_WIDTH+2+7)/8)*8;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOOK = 3'b010,
        S_UPD  = 3'b100
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic [CAP_W-1:0]         cap_reg;
    logic [CNT_W-1:0]         used_reg;
    logic [CNT_W-1:0]         used_next;
    logic                     cmd_reg;
    logic [KEY_W-1:0]         key_reg;
    logic [PAYLOAD_WIDTH-1:0] pay_reg;
    logic                     out_valid_reg;
    logic [OUT_W-1:0]         out_data_reg;

    logic [CMP_W-1:0]         cap_ext;
    logic [CMP_W-1:0]         cap_min;
    logic [CMP_W-1:0]         cap_eff;
    logic                     full;
    logic                     upd_go;
    logic                     found;
    logic [PAYLOAD_WIDTH-1:0] hit_pay;
    logic [RANK_W-1:0]        hit_rank;
    logic                     evict;
    cell_ctl_t                ctl;

    logic                     found_chain [0:ENTRIES];
    logic [PAYLOAD_WIDTH-1:0] pay_chain   [0:ENTRIES];
    logic [RANK_W-1:0]        rank_chain  [0:ENTRIES];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign cap_ext = CMP_W'(cap_reg);
    assign cap_min = (cap_ext == '0) ? CMP_W'(1) : cap_ext;
    assign cap_eff = (cap_min > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_min;
    assign full    = (used_reg != '0) && (CMP_W'(used_reg) >= cap_eff);

    assign found_chain[0] = 1'b0;
    assign pay_chain[0]   = '0;
    assign rank_chain[0]  = '0;
    assign found    = found_chain[ENTRIES];
    assign hit_pay  = pay_chain[ENTRIES];
    assign hit_rank = rank_chain[ENTRIES];

    assign upd_go = (state_reg == S_UPD) && (!out_valid_reg || m_axis_tready);
    assign evict  = (cmd_reg == CMD_PUT) && !found && full;

    assign ctl.look     = (state_reg == S_LOOK);
    assign ctl.apply    = upd_go;
    assign ctl.is_put   = (cmd_reg == CMD_PUT);
    assign ctl.is_hit   = found;
    assign ctl.do_evict = evict;

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_cell
            lkvc_cell #(
                .ENTRIES       (ENTRIES),
                .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
                .CELL_IDX      (gi)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .key        (key_reg),
                .pay        (pay_reg),
                .used_count (used_reg),
                .hit_rank   (hit_rank),
                .found_in   (found_chain[gi]),
                .pay_in     (pay_chain[gi]),
                .rank_in    (rank_chain[gi]),
                .found_out  (found_chain[gi+1]),
                .pay_out    (pay_chain[gi+1]),
                .rank_out   (rank_chain[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (upd_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        used_next = used_reg;
        if (upd_go && (cmd_reg == CMD_PUT) && !found && !evict)
        begin
            used_next = used_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= CAP_RESET;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
            if (upd_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            cmd_reg <= s_axis_tuser;
            key_reg <= s_axis_tdata[KEY_W-1:0];
            pay_reg <= s_axis_tdata[KEY_W +: PAYLOAD_WIDTH];
        end
        if (upd_go)
        begin
            out_data_reg <= OUT_W'({evict,
                                    ((cmd_reg == CMD_GET) && found) ? hit_pay
                                                                    : {PAYLOAD_WIDTH{1'b0}},
                                    found});
        end
    end

endmodule
`default_nettype wire
